// ----- sv/lbfv_pkg.sv -----
// lbfv_pkg: shared widths, status codes and pipeline payload types for the
// four-vector boost block; used by lbfv_div and lorentz_boost_four_vector
package lbfv_pkg;

    // field and datapath widths
    localparam int MOM_W   = 32;
    localparam int BETA_W  = 32;
    localparam int BMAG_W  = 30;
    localparam int SQRT_W  = 31;
    localparam int QUO_W   = 33;
    localparam int E_NUM_W = 64;
    localparam int E_DEN_W = 31;
    localparam int T_NUM_W = 94;
    localparam int T_DEN_W = 62;

    // result status codes
    typedef enum logic [1:0] {
        STAT_BOOSTED = 2'd0,
        STAT_ZERO    = 2'd1,
        STAT_FAST    = 2'd2
    } status_t;

    // per-item data that rides alongside the arithmetic
    typedef struct packed {
        logic [2:0][MOM_W-1:0]  mom;
        logic [MOM_W-1:0]       energy;
        logic [2:0]             bneg;
        logic [2:0][BMAG_W-1:0] bmag;
        status_t                status;
    } side_t;

    // what the divider stages need to carry besides the quotients
    typedef struct packed {
        side_t side;
        logic  ne_neg;
        logic  m_neg;
    } tail_t;

endpackage

// ----- sv/lbfv_div.sv -----
// lbfv_div: pipelined restoring divider, one quotient bit per stage, with
// round-to-nearest and a cap at 2^QUO_W; depends on lbfv_pkg for defaults
module lbfv_div #(
    parameter int NUM_W = lbfv_pkg::T_NUM_W,
    parameter int DEN_W = lbfv_pkg::T_DEN_W,
    parameter int QUO_W = lbfv_pkg::QUO_W
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W:0]   quo
);

    localparam int HI_W  = NUM_W - QUO_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam logic [QUO_W:0] QUO_CAP = {1'b1, {QUO_W{1'b0}}};

    logic [DEN_W-1:0] rem_reg [QUO_W+1];
    logic [QUO_W-1:0] low_reg [QUO_W];
    logic [QUO_W-1:0] q_reg   [QUO_W+1];
    logic [DEN_W-1:0] den_reg [QUO_W+1];
    logic             over_reg[QUO_W+1];
    logic [QUO_W:0]   quo_reg;
    logic             over_next;
    logic             rnd;

    // quotient too large for QUO_W bits when the top part already reaches den
    assign over_next = CMP_W'(num[NUM_W-1:QUO_W]) >= CMP_W'(den);

    // entry stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DEN_W'(num[NUM_W-1:QUO_W]);
            low_reg[0]  <= num[QUO_W-1:0];
            q_reg[0]    <= '0;
            den_reg[0]  <= den;
            over_reg[0] <= over_next;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic           ge;

        assign trial = {rem_reg[k], low_reg[k][QUO_W-1]};
        assign ge    = trial >= {1'b0, den_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? DEN_W'(trial - {1'b0, den_reg[k]}) : DEN_W'(trial);
                q_reg[k+1]    <= {q_reg[k][QUO_W-2:0], ge};
                den_reg[k+1]  <= den_reg[k];
                over_reg[k+1] <= over_reg[k];
            end
        end

        if (k + 1 < QUO_W)
        begin : g_low
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    low_reg[k+1] <= low_reg[k] << 1;
                end
            end
        end
    end

    // round half up on the remainder, then cap
    assign rnd = {rem_reg[QUO_W], 1'b0} >= {1'b0, den_reg[QUO_W]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= over_reg[QUO_W] ? QUO_CAP
                                       : {1'b0, q_reg[QUO_W]} + (QUO_W+1)'(rnd);
        end
    end

    assign quo = quo_reg;

endmodule

// ----- sv/lorentz_boost_four_vector.sv -----
// lorentz_boost_four_vector: boosts a four-momentum (Q23.8) by a velocity
// beta (Q1.30); depends on lbfv_pkg and lbfv_div.
//
// Input channel in_valid/in_stall carries mom_x/y/z, mom_energy and
// beta_x/y/z; output channel out_valid/out_stall carries out_x/y/z,
// out_energy and boost_status. A transfer happens on a rising edge with
// valid high and stall low.
// A new item can be taken every cycle unless out_stall freezes the pipeline.
// From input transfer to out_valid an item passes 2 product/sum stages, a
// 32-stage square root (entry register plus one result bit per stage), 6
// stages of rounding, multiplies and sign handling, then 35 stages of the
// restoring dividers (one quotient bit per stage) and the output register.
// Zero beta returns the input with status 1; |beta| >= 1 returns the input
// with status 2; otherwise status 0 and results rounded and saturated.
// Reset clears all valid bits, so the pipeline comes up empty.
// When out_stall holds off a waiting result the whole pipeline freezes and
// in_stall is raised in the same cycle; nothing is dropped or repeated.
module lorentz_boost_four_vector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] mom_x,
    input  logic [31:0] mom_y,
    input  logic [31:0] mom_z,
    input  logic [31:0] mom_energy,
    input  logic [31:0] beta_x,
    input  logic [31:0] beta_y,
    input  logic [31:0] beta_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic [31:0] out_energy,
    output logic [1:0]  boost_status
);

    localparam int SQ_STAGES = lbfv_pkg::SQRT_W;
    localparam int QW        = lbfv_pkg::QUO_W;
    localparam int DIV_LAT   = QW + 2;
    localparam logic [61:0] B2_ONE = 62'd1 << 60;
    localparam logic [31:0] S1_OFS = 32'd1 << 30;
    localparam logic [30:0] S_MAX  = 31'd1 << 30;

    function automatic logic [31:0] sat32(input logic [35:0] v);
        logic [31:0] r;
        if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111)
        begin
            r = v[31:0];
        end
        else
        begin
            r = v[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    logic adv;

    // stage valids
    logic                 v1_reg, v2_reg;
    logic [SQ_STAGES:0]   sq_v_reg;
    logic                 vr_reg, vc_reg, vd_reg, ve_reg, vf_reg, vg_reg;
    logic [DIV_LAT-1:0]   dl_v_reg;
    logic                 out_valid_reg;

    // pipeline advances unless a finished result is held off
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            sq_v_reg      <= '0;
            vr_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            vd_reg        <= 1'b0;
            ve_reg        <= 1'b0;
            vf_reg        <= 1'b0;
            vg_reg        <= 1'b0;
            dl_v_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            sq_v_reg      <= {sq_v_reg[SQ_STAGES-1:0], v2_reg};
            vr_reg        <= sq_v_reg[SQ_STAGES];
            vc_reg        <= vr_reg;
            vd_reg        <= vc_reg;
            ve_reg        <= vd_reg;
            vf_reg        <= ve_reg;
            vg_reg        <= vf_reg;
            dl_v_reg      <= {dl_v_reg[DIV_LAT-2:0], vg_reg};
            out_valid_reg <= dl_v_reg[DIV_LAT-1];
        end
    end

    // input decode: beta magnitudes and special cases
    logic [2:0][31:0]     mom_in, beta_in, babs;
    logic [2:0]           bneg_in, big_in;
    lbfv_pkg::status_t    status_in;

    assign mom_in  = {mom_z, mom_y, mom_x};
    assign beta_in = {beta_z, beta_y, beta_x};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            bneg_in[i] = beta_in[i][31];
            babs[i]    = bneg_in[i] ? (32'd0 - beta_in[i]) : beta_in[i];
            big_in[i]  = |babs[i][31:30];
        end
        if (beta_in == '0)
        begin
            status_in = lbfv_pkg::STAT_ZERO;
        end
        else if (|big_in)
        begin
            status_in = lbfv_pkg::STAT_FAST;
        end
        else
        begin
            status_in = lbfv_pkg::STAT_BOOSTED;
        end
    end

    // stage 1: squares of beta and momentum-beta products
    lbfv_pkg::side_t  side1_reg;
    logic [2:0][59:0] sq1_reg;
    logic [2:0][63:0] pb1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                side1_reg.mom[i]  <= mom_in[i];
                side1_reg.bneg[i] <= bneg_in[i];
                side1_reg.bmag[i] <= babs[i][29:0];
                sq1_reg[i]        <= babs[i][29:0] * babs[i][29:0];
                pb1_reg[i]        <= $signed(mom_in[i]) * $signed(beta_in[i]);
            end
            side1_reg.energy <= mom_energy;
            side1_reg.status <= status_in;
        end
    end

    // stage 2: |beta|^2 and beta.p
    lbfv_pkg::side_t side2_reg;
    logic [61:0]     b2_reg;
    logic [63:0]     bp2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side2_reg <= side1_reg;
            b2_reg    <= 62'(sq1_reg[0]) + 62'(sq1_reg[1]) + 62'(sq1_reg[2]);
            bp2_reg   <= pb1_reg[0] + pb1_reg[1] + pb1_reg[2];
        end
    end

    // square root entry: flag |beta| >= 1, form 1 - |beta|^2
    lbfv_pkg::side_t side3_next;

    always_comb
    begin
        side3_next = side2_reg;
        if (side2_reg.status == lbfv_pkg::STAT_BOOSTED && b2_reg >= B2_ONE)
        begin
            side3_next.status = lbfv_pkg::STAT_FAST;
        end
    end

    lbfv_pkg::side_t sq_side_reg [SQ_STAGES+1];
    logic [63:0]     sq_bp_reg   [SQ_STAGES+1];
    logic [32:0]     sq_rem_reg  [SQ_STAGES+1];
    logic [30:0]     sq_root_reg [SQ_STAGES+1];
    logic [61:0]     sq_rad_reg  [SQ_STAGES];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_side_reg[0] <= side3_next;
            sq_bp_reg[0]   <= bp2_reg;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_rad_reg[0]  <= {1'b0, 61'(B2_ONE) - b2_reg[60:0]};
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_sqrt
        logic [34:0] part;
        logic [34:0] trial;
        logic        ge;

        assign part  = {sq_rem_reg[k], sq_rad_reg[k][61:60]};
        assign trial = {2'b00, sq_root_reg[k], 2'b01};
        assign ge    = part >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_side_reg[k+1] <= sq_side_reg[k];
                sq_bp_reg[k+1]   <= sq_bp_reg[k];
                sq_rem_reg[k+1]  <= ge ? 33'(part - trial) : 33'(part);
                sq_root_reg[k+1] <= {sq_root_reg[k][29:0], ge};
            end
        end

        if (k + 1 < SQ_STAGES)
        begin : g_rad
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_rad_reg[k+1] <= sq_rad_reg[k] << 2;
                end
            end
        end
    end

    // root rounding to nearest: s, and 1 + s in Q30
    lbfv_pkg::side_t sr_side_reg;
    logic [63:0]     sr_bp_reg;
    logic [30:0]     s_reg;
    logic [31:0]     s1_reg;
    logic            root_rnd;
    logic [30:0]     s_next;

    assign root_rnd = sq_rem_reg[SQ_STAGES] > {2'b00, sq_root_reg[SQ_STAGES]};
    assign s_next   = sq_root_reg[SQ_STAGES] + 31'(root_rnd);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sr_side_reg <= sq_side_reg[SQ_STAGES];
            sr_bp_reg   <= sq_bp_reg[SQ_STAGES];
            s_reg       <= s_next;
            s1_reg      <= {1'b0, s_next} + S1_OFS;
        end
    end

    // energy numerator, E*(1+s) and the term denominator s*(1+s)
    lbfv_pkg::side_t    sc_side_reg;
    logic [63:0]        sc_bp_reg;
    logic [64:0]        sc_ne_reg;
    logic [63:0]        sc_ta_reg;
    logic [61:0]        sc_den_reg;
    logic [30:0]        sc_s_reg;
    logic [64:0]        e_shift;
    logic signed [64:0] ta_full;

    assign e_shift = {{3{sr_side_reg.energy[31]}}, sr_side_reg.energy, 30'b0};
    assign ta_full = $signed(sr_side_reg.energy) * $signed({1'b0, s1_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_side_reg <= sr_side_reg;
            sc_bp_reg   <= sr_bp_reg;
            sc_ne_reg   <= e_shift + {sr_bp_reg[63], sr_bp_reg};
            sc_ta_reg   <= ta_full[63:0];
            sc_den_reg  <= s_reg * s1_reg;
            sc_s_reg    <= s_reg;
        end
    end

    // sum the term numerator, split energy numerator into sign and size
    lbfv_pkg::side_t sd_side_reg;
    logic            sd_ne_neg_reg;
    logic [63:0]     sd_ne_mag_reg;
    logic [64:0]     sd_m_reg;
    logic [61:0]     sd_den_reg;
    logic [30:0]     sd_s_reg;
    logic [64:0]     ne_neg_val;

    assign ne_neg_val = 65'd0 - sc_ne_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_side_reg   <= sc_side_reg;
            sd_ne_neg_reg <= sc_ne_reg[64];
            sd_ne_mag_reg <= sc_ne_reg[64] ? ne_neg_val[63:0] : sc_ne_reg[63:0];
            sd_m_reg      <= {sc_bp_reg[63], sc_bp_reg} + {sc_ta_reg[63], sc_ta_reg};
            sd_den_reg    <= sc_den_reg;
            sd_s_reg      <= sc_s_reg;
        end
    end

    // term numerator into sign and size
    lbfv_pkg::side_t se_side_reg;
    logic            se_ne_neg_reg;
    logic [63:0]     se_ne_mag_reg;
    logic            se_m_neg_reg;
    logic [63:0]     se_mmag_reg;
    logic [61:0]     se_den_reg;
    logic [30:0]     se_s_reg;
    logic [64:0]     m_neg_val;

    assign m_neg_val = 65'd0 - sd_m_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            se_side_reg   <= sd_side_reg;
            se_ne_neg_reg <= sd_ne_neg_reg;
            se_ne_mag_reg <= sd_ne_mag_reg;
            se_m_neg_reg  <= sd_m_reg[64];
            se_mmag_reg   <= sd_m_reg[64] ? m_neg_val[63:0] : sd_m_reg[63:0];
            se_den_reg    <= sd_den_reg;
            se_s_reg      <= sd_s_reg;
        end
    end

    // |beta_i| times numerator, as two 30x32 partial products per lane
    lbfv_pkg::side_t  sf_side_reg;
    logic             sf_ne_neg_reg;
    logic [63:0]      sf_ne_mag_reg;
    logic             sf_m_neg_reg;
    logic [2:0][61:0] sf_pp_lo_reg;
    logic [2:0][61:0] sf_pp_hi_reg;
    logic [61:0]      sf_den_reg;
    logic [30:0]      sf_s_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sf_pp_lo_reg[i] <= se_side_reg.bmag[i] * se_mmag_reg[31:0];
                sf_pp_hi_reg[i] <= se_side_reg.bmag[i] * se_mmag_reg[63:32];
            end
            sf_side_reg   <= se_side_reg;
            sf_ne_neg_reg <= se_ne_neg_reg;
            sf_ne_mag_reg <= se_ne_mag_reg;
            sf_m_neg_reg  <= se_m_neg_reg;
            sf_den_reg    <= se_den_reg;
            sf_s_reg      <= se_s_reg;
        end
    end

    // combine partial products
    lbfv_pkg::tail_t  sg_tail_reg;
    logic [63:0]      sg_ne_mag_reg;
    logic [2:0][93:0] sg_num_reg;
    logic [61:0]      sg_den_reg;
    logic [30:0]      sg_s_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sg_num_reg[i] <= 94'(sf_pp_lo_reg[i]) + {sf_pp_hi_reg[i], 32'b0};
            end
            sg_tail_reg.side   <= sf_side_reg;
            sg_tail_reg.ne_neg <= sf_ne_neg_reg;
            sg_tail_reg.m_neg  <= sf_m_neg_reg;
            sg_ne_mag_reg      <= sf_ne_mag_reg;
            sg_den_reg         <= sf_den_reg;
            sg_s_reg           <= sf_s_reg;
        end
    end

    // dividers: energy by s, each momentum term by s*(1+s)
    logic [QW:0]      quo_e;
    logic [2:0][QW:0] quo_t;

    lbfv_div #(
        .NUM_W (lbfv_pkg::E_NUM_W),
        .DEN_W (lbfv_pkg::E_DEN_W),
        .QUO_W (QW)
    ) u_div_e (
        .clk (clk),
        .en  (adv),
        .num (sg_ne_mag_reg),
        .den (sg_s_reg),
        .quo (quo_e)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_div_t
        lbfv_div #(
            .NUM_W (lbfv_pkg::T_NUM_W),
            .DEN_W (lbfv_pkg::T_DEN_W),
            .QUO_W (QW)
        ) u_div_t (
            .clk (clk),
            .en  (adv),
            .num (sg_num_reg[i]),
            .den (sg_den_reg),
            .quo (quo_t[i])
        );
    end

    // side data delayed to match the dividers
    lbfv_pkg::tail_t dl_tail_reg [DIV_LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dl_tail_reg[0] <= sg_tail_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                dl_tail_reg[k] <= dl_tail_reg[k-1];
            end
        end
    end

    // apply signs, add to momentum, saturate, or pass the input through
    lbfv_pkg::tail_t  tl;
    logic [2:0][35:0] mom_sum;
    logic [35:0]      e_sum;
    logic [2:0][31:0] mom_res;
    logic [31:0]      e_res;
    logic [31:0]      out_x_reg, out_y_reg, out_z_reg, out_energy_reg;
    logic [1:0]       boost_status_reg;

    assign tl = dl_tail_reg[DIV_LAT-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (tl.side.bneg[i] != tl.m_neg)
            begin
                mom_sum[i] = {{4{tl.side.mom[i][31]}}, tl.side.mom[i]} - 36'(quo_t[i]);
            end
            else
            begin
                mom_sum[i] = {{4{tl.side.mom[i][31]}}, tl.side.mom[i]} + 36'(quo_t[i]);
            end
        end
        e_sum = tl.ne_neg ? (36'd0 - 36'(quo_e)) : 36'(quo_e);
        if (tl.side.status == lbfv_pkg::STAT_BOOSTED)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mom_res[i] = sat32(mom_sum[i]);
            end
            e_res = sat32(e_sum);
        end
        else
        begin
            mom_res = tl.side.mom;
            e_res   = tl.side.energy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x_reg        <= mom_res[0];
            out_y_reg        <= mom_res[1];
            out_z_reg        <= mom_res[2];
            out_energy_reg   <= e_res;
            boost_status_reg <= tl.side.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign out_z        = out_z_reg;
    assign out_energy   = out_energy_reg;
    assign boost_status = boost_status_reg;

    // radicand of a boosted item is never zero
    a_rad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_v_reg[0] && sq_side_reg[0].status == lbfv_pkg::STAT_BOOSTED)
        |-> (sq_rad_reg[0] != '0))
        else $error("square root radicand is zero for a boosted item");

    // rounded root lies in [1, 2^30] for a boosted item
    a_s_range: assert property (@(posedge clk) disable iff (!rst_n)
        (vr_reg && sr_side_reg.status == lbfv_pkg::STAT_BOOSTED)
        |-> (s_reg != '0 && s_reg <= S_MAX))
        else $error("rounded root out of range");

    // an item leaving the multiply stages enters the divider delay line
    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && vg_reg) |=> dl_v_reg[0])
        else $error("item lost entering the divider stages");

    // a frozen pipeline keeps its result in place
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && dl_v_reg[DIV_LAT-1]) |=> dl_v_reg[DIV_LAT-1])
        else $error("item lost while the pipeline was frozen");

endmodule

// ----- tb/lorentz_boost_four_vector_tb.sv -----
// lorentz_boost_four_vector_tb: self-checking bench for the four-vector boost;
// depends on lbfv_pkg and lorentz_boost_four_vector. directed table then random
// traffic, each result checked against its typed table entry or an in-bench fixed-point boost predictor
`timescale 1ns / 1ps

module lorentz_boost_four_vector_tb;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [31:0] px, py, pz, en, bx, by, bz;
    } four_in_t;

    typedef struct {
        logic [31:0]       x, y, z, energy;
        lbfv_pkg::status_t status;
    } boosted_t;

    typedef struct {
        four_in_t in;
        bit       typed;
        boosted_t res;
    } stim_row_t;

    localparam wide_t ONE30 = wide_t'(1) <<< 30;
    localparam wide_t ONE60 = wide_t'(1) <<< 60;
    localparam wide_t QCAP  = wide_t'(1) <<< 33;
    localparam int    B_ONE = 1 << 30;
    localparam int    N_RANDOM = 1800;
    localparam int    HOLD_AT = 300;
    localparam int    HOLD_LEN = 250;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] mom_x, mom_y, mom_z, mom_energy, beta_x, beta_y, beta_z;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] out_x, out_y, out_z, out_energy;
    logic [1:0]  boost_status;

    stim_row_t stim_rows[$];
    boosted_t  pending_boosts[$];
    int        mismatch_count;
    int        received_count;
    bit        sending_done;

    lorentz_boost_four_vector i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mom_x        (mom_x),
        .mom_y        (mom_y),
        .mom_z        (mom_z),
        .mom_energy   (mom_energy),
        .beta_x       (beta_x),
        .beta_y       (beta_y),
        .beta_z       (beta_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z),
        .out_energy   (out_energy),
        .boost_status (boost_status)
    );

    // clock, 20 ns period
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // rounded integer square root, nearest
    function automatic wide_t root_nearest(input wide_t v);
        wide_t r, res, b;
        r = v;
        res = 0;
        b = wide_t'(1) <<< 62;
        while (b > r)
            b = b >>> 2;
        while (b != 0)
        begin
            if (r >= res + b)
            begin
                r = r - (res + b);
                res = (res >>> 1) + b;
            end
            else
                res = res >>> 1;
            b = b >>> 2;
        end
        if (r > res)
            res = res + 1;
        return res;
    endfunction

    // quotient rounded half away from zero, capped at 2^33
    function automatic wide_t quot_round(input wide_t n, input wide_t d);
        wide_t q, r;
        q = n / d;
        r = n % d;
        if (2 * r >= d)
            q = q + 1;
        if (q > QCAP)
            q = QCAP;
        return q;
    endfunction

    function automatic logic [31:0] clamp32(input wide_t v);
        if (v > wide_t'(32'sh7fffffff))
            return 32'h7fffffff;
        if (v < -(wide_t'(1) <<< 31))
            return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic wide_t mag(input wide_t v);
        return (v < 0) ? -v : v;
    endfunction

    // expected boost of one four-vector
    function automatic boosted_t boost_predict(input four_in_t it);
        wide_t    p[3], b[3];
        wide_t    e, b2, s, bp, ne, m, den, q, v;
        boosted_t res;
        p[0] = wide_t'(it.px);
        p[1] = wide_t'(it.py);
        p[2] = wide_t'(it.pz);
        b[0] = wide_t'(it.bx);
        b[1] = wide_t'(it.by);
        b[2] = wide_t'(it.bz);
        e = wide_t'(it.en);
        res.x = it.px;
        res.y = it.py;
        res.z = it.pz;
        res.energy = it.en;
        b2 = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
        if (b2 == 0)
        begin
            res.status = lbfv_pkg::STAT_ZERO;
            return res;
        end
        if (b2 >= ONE60)
        begin
            res.status = lbfv_pkg::STAT_FAST;
            return res;
        end
        s = root_nearest(ONE60 - b2);
        if (s == 0)
            s = 1;
        bp = p[0] * b[0] + p[1] * b[1] + p[2] * b[2];
        ne = e * ONE30 + bp;
        q = quot_round(mag(ne), s);
        res.energy = clamp32((ne < 0) ? -q : q);
        m = bp + e * (ONE30 + s);
        den = s * (ONE30 + s);
        for (int i = 0; i < 3; i++)
        begin
            q = quot_round(mag(b[i]) * mag(m), den);
            v = ((b[i] < 0) != (m < 0)) ? p[i] - q : p[i] + q;
            case (i)
                0: res.x = clamp32(v);
                1: res.y = clamp32(v);
                default: res.z = clamp32(v);
            endcase
        end
        res.status = lbfv_pkg::STAT_BOOSTED;
        return res;
    endfunction

    function automatic stim_row_t make_row(input int px, py, pz, en, bx, by, bz,
                                           input bit typed, input lbfv_pkg::status_t st);
        stim_row_t row;
        row.in.px = px;
        row.in.py = py;
        row.in.pz = pz;
        row.in.en = en;
        row.in.bx = bx;
        row.in.by = by;
        row.in.bz = bz;
        row.typed = typed;
        // typed rows are pass-through cases, so the result is the input
        row.res.x = px;
        row.res.y = py;
        row.res.z = pz;
        row.res.energy = en;
        row.res.status = st;
        return row;
    endfunction

    function automatic int rand_beta(input int span);
        return $urandom_range(2 * span, 0) - span;
    endfunction

    // random item: mostly sub-light boosts, some zero and faster than light
    function automatic stim_row_t random_row();
        int        mode;
        int        mom_bits;
        int        near;
        stim_row_t row;
        mode = $urandom_range(99, 0);
        mom_bits = ($urandom_range(3, 0) == 0) ? 32 : $urandom_range(31, 8);
        row = make_row(0, 0, 0, 0, 0, 0, 0, 1'b0, lbfv_pkg::STAT_BOOSTED);
        row.in.px = $signed($urandom()) >>> (32 - mom_bits);
        row.in.py = $signed($urandom()) >>> (32 - mom_bits);
        row.in.pz = $signed($urandom()) >>> (32 - mom_bits);
        row.in.en = $signed($urandom()) >>> (32 - mom_bits);
        if (mode < 5)
        begin
            row.in.bx = 0;
            row.in.by = 0;
            row.in.bz = 0;
        end
        else if (mode < 15)
        begin
            row.in.bx = rand_beta(B_ONE);
            row.in.by = rand_beta(B_ONE);
            row.in.bz = rand_beta(B_ONE);
            if ($urandom_range(1, 0))
                row.in.bx = $urandom_range(1, 0) ? B_ONE : -B_ONE;
        end
        else if (mode < 30)
        begin
            // one axis close to light speed
            near = B_ONE - int'($urandom_range(4095, 1));
            if ($urandom_range(1, 0))
                near = -near;
            row.in.bx = 0;
            row.in.by = 0;
            row.in.bz = 0;
            case ($urandom_range(2, 0))
                0: row.in.bx = near;
                1: row.in.by = near;
                default: row.in.bz = near;
            endcase
        end
        else
        begin
            row.in.bx = rand_beta(1 << 29);
            row.in.by = rand_beta(1 << 29);
            row.in.bz = rand_beta(1 << 29);
        end
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got, exp);
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, exp,
                 received_count);
        mismatch_count++;
    endtask

    // stimulus table and sender
    initial
    begin
        int gap;
        boosted_t exp_res;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mom_x = '0;
        mom_y = '0;
        mom_z = '0;
        mom_energy = '0;
        beta_x = '0;
        beta_y = '0;
        beta_z = '0;
        sending_done = 1'b0;
        mismatch_count = 0;

        // zero beta passes through
        stim_rows.push_back(make_row(32'h7fffffff, 32'h80000000, 0, -1, 0, 0, 0,
                                     1, lbfv_pkg::STAT_ZERO));
        stim_rows.push_back(make_row(32'h80000000, 32'h7fffffff, -1, 32'h7fffffff, 0, 0, 0,
                                     1, lbfv_pkg::STAT_ZERO));
        // at or above light speed passes through
        stim_rows.push_back(make_row(100, 200, 300, 400, B_ONE, 0, 0,
                                     1, lbfv_pkg::STAT_FAST));
        stim_rows.push_back(make_row(-5, 6, -7, 8, 0, 0, -B_ONE,
                                     1, lbfv_pkg::STAT_FAST));
        stim_rows.push_back(make_row(1, 2, 3, 4, 0, -B_ONE, 0,
                                     1, lbfv_pkg::STAT_FAST));
        stim_rows.push_back(make_row(1, 2, 3, 4, 3 << 28, 3 << 28, 0,
                                     1, lbfv_pkg::STAT_FAST));
        stim_rows.push_back(make_row(32'h7fffffff, 0, 0, 32'h80000000, B_ONE, B_ONE, B_ONE,
                                     1, lbfv_pkg::STAT_FAST));
        // ordinary and extreme boosts, predicted
        stim_rows.push_back(make_row(0, 0, 0, 256 * 938, 0, 0, 1 << 29,
                                     0, lbfv_pkg::STAT_BOOSTED));
        stim_rows.push_back(make_row(256, -256, 512, 256 * 1000, 1 << 28, -(1 << 28), 1 << 27,
                                     0, lbfv_pkg::STAT_BOOSTED));
        stim_rows.push_back(make_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                     B_ONE - 1, 0, 0, 0, lbfv_pkg::STAT_BOOSTED));
        stim_rows.push_back(make_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                                     -(B_ONE - 1), 0, 0, 0, lbfv_pkg::STAT_BOOSTED));
        stim_rows.push_back(make_row(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                                     0, B_ONE - 1, 0, 0, lbfv_pkg::STAT_BOOSTED));
        stim_rows.push_back(make_row(1000, 2000, 3000, 32'h80000000, 0, 0, -(B_ONE - 1),
                                     0, lbfv_pkg::STAT_BOOSTED));
        stim_rows.push_back(make_row(0, 0, 0, 0, 1, 0, 0,
                                     0, lbfv_pkg::STAT_BOOSTED));
        stim_rows.push_back(make_row(-1, -1, -1, -1, -1, -1, -1,
                                     0, lbfv_pkg::STAT_BOOSTED));
        stim_rows.push_back(make_row(12345, -678, 91011, 500000, 619925131, 619925131,
                                     619925131, 0, lbfv_pkg::STAT_BOOSTED));
        stim_rows.push_back(make_row(32'h7fffffff, 0, 0, 0, 32'hc0000001, 0, 0,
                                     0, lbfv_pkg::STAT_BOOSTED));
        stim_rows.push_back(make_row(32'h55555555, 32'haaaaaaaa, 32'h33333333, 32'hcccccccc,
                                     32'h2aaaaaaa, 32'hd5555556, 32'h15555555,
                                     0, lbfv_pkg::STAT_BOOSTED));
        for (int i = 0; i < N_RANDOM; i++)
            stim_rows.push_back(random_row());

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
        begin
            gap = $urandom_range(9, 0);
            if (i % 200 < 40)
                gap = 0;
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            @(negedge clk);
            in_valid <= 1'b1;
            mom_x <= stim_rows[i].in.px;
            mom_y <= stim_rows[i].in.py;
            mom_z <= stim_rows[i].in.pz;
            mom_energy <= stim_rows[i].in.en;
            beta_x <= stim_rows[i].in.bx;
            beta_y <= stim_rows[i].in.by;
            beta_z <= stim_rows[i].in.bz;
            do
                @(posedge clk);
            while (in_stall);
            // transfer accepted at this edge
            exp_res = stim_rows[i].typed ? stim_rows[i].res : boost_predict(stim_rows[i].in);
            pending_boosts.push_back(exp_res);
        end
        @(negedge clk);
        in_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // receiver: random stalls, one long hold-off to fill the pipeline
    initial
    begin
        int hold;
        out_stall = 1'b1;
        received_count = 0;
        @(posedge rst_n);
        forever
        begin
            hold = $urandom_range(9, 0);
            if ((received_count / 150) % 3 == 2)
                hold = 0;
            if (received_count == HOLD_AT)
                hold = HOLD_LEN;
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            // result transfer at this edge
            if (pending_boosts.size() == 0)
            begin
                report_mismatch("unexpected result out_x", out_x, 32'h0);
            end
            else
            begin
                boosted_t exp_res;
                exp_res = pending_boosts.pop_front();
                if (out_x !== exp_res.x)
                    report_mismatch("out_x", out_x, exp_res.x);
                if (out_y !== exp_res.y)
                    report_mismatch("out_y", out_y, exp_res.y);
                if (out_z !== exp_res.z)
                    report_mismatch("out_z", out_z, exp_res.z);
                if (out_energy !== exp_res.energy)
                    report_mismatch("out_energy", out_energy, exp_res.energy);
                if (boost_status !== exp_res.status)
                    report_mismatch("boost_status", 32'(boost_status), 32'(exp_res.status));
            end
            received_count++;
        end
    end

    // end of run
    initial
    begin
        wait (sending_done);
        while (pending_boosts.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        if (mismatch_count == 0)
            $display("lorentz_boost_four_vector_tb OK");
        else
            $display("lorentz_boost_four_vector_tb NOT OK");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("lorentz_boost_four_vector_tb NOT OK");
        $finish;
    end

endmodule
